[rtl/core/hds_pkg.sv]
// Shared types and constants of the heat diffusion stencil core.
package hds_pkg;

  localparam int unsigned MaxRowLength = 1024;
  localparam int unsigned ColW         = $clog2(MaxRowLength);
  localparam int unsigned LenEffW      = ColW + 1;

  localparam int unsigned LenW    = 11;
  localparam int unsigned RowW    = 16;
  localparam int unsigned FactorW = 15;
  localparam int unsigned ValW    = 16;

  localparam int unsigned DiffW = ValW + 3;
  localparam int unsigned ProdW = DiffW + FactorW + 1;
  localparam int unsigned SumW  = DiffW + 1;

  localparam int unsigned OpqDepth  = 4;
  localparam int unsigned OpqIdxW   = $clog2(OpqDepth);
  localparam int unsigned OpqCntW   = $clog2(OpqDepth + 1);
  localparam int unsigned OutqDepth = 8;
  localparam int unsigned OutqIdxW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [1:0] RegRowLength  = 2'd0;
  localparam logic [1:0] RegRowCount   = 2'd1;
  localparam logic [1:0] RegStepFactor = 2'd2;

  typedef struct packed {
    logic [LenW-1:0]    row_length;
    logic [RowW-1:0]    row_count;
    logic [FactorW-1:0] step_factor;
  } cfg_t;

  typedef struct packed {
    logic [ValW-1:0] center;
    logic [ValW-1:0] north;
    logic [ValW-1:0] west;
    logic [ValW-1:0] east;
    logic [ValW-1:0] south;
    logic            upd;
    logic            second;
    logic            done;
  } op_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
    logic            done;
  } res_t;

endpackage

[rtl/core/hds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hds_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hds_front.sv]
// Front end: raster position tracking, line stores and stencil operand gathering.
module hds_front import hds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                restart_i,
  input  logic                push_i,
  input  logic [ValW-1:0]     cell_value_i,
  input  logic [OpqCntW-1:0]  opq_count_i,
  output logic                full_o,
  output logic                op_push_o,
  output op_t                 op_o
);

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ValW-1:0]    left_q;
  logic [LenEffW-1:0] len_eff;
  logic [RowW-1:0]    cnt_eff;
  logic               last_col, last_row, accept;

  logic               s1_valid_q;
  logic [ColW-1:0]    s1_col_q;
  logic [ValW-1:0]    s1_cell_q;
  logic               s1_row0_q, s1_row1_q, s1_last_row_q, s1_last_col_q, s1_col0_q;

  logic [ValW-1:0]    north_rd, center_rd, east_rd;
  logic [OpqCntW:0]   pending;

  always_comb begin
    if (cfg_i.row_length < LenW'(3)) begin
      len_eff = LenEffW'(3);
    end else if (32'(cfg_i.row_length) > MaxRowLength) begin
      len_eff = LenEffW'(MaxRowLength);
    end else begin
      len_eff = LenEffW'(cfg_i.row_length);
    end
    cnt_eff = (cfg_i.row_count < RowW'(3)) ? RowW'(3) : cfg_i.row_count;
  end

  assign pending  = (OpqCntW+1)'(opq_count_i) + (OpqCntW+1)'(s1_valid_q);
  assign full_o   = (32'(pending) >= OpqDepth);
  assign accept   = push_i && !full_o;
  assign last_col = ({1'b0, col_q} == (len_eff - LenEffW'(1)));
  assign last_row = (row_q == (cnt_eff - RowW'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        left_q <= center_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q      <= col_q;
      s1_cell_q     <= cell_value_i;
      s1_row0_q     <= (row_q == '0);
      s1_row1_q     <= (row_q == RowW'(1));
      s1_last_row_q <= last_row;
      s1_last_col_q <= last_col;
      s1_col0_q     <= (col_q == '0);
    end
  end

  hds_ram #(.Width(ValW), .Depth(MaxRowLength)) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (center_rd),
    .raddr_i (col_q),
    .rdata_o (north_rd)
  );

  hds_ram #(.Width(ValW), .Depth(MaxRowLength)) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cell_q),
    .raddr_i (col_q),
    .rdata_o (center_rd)
  );

  // copy of the middle line for the east neighbor read
  hds_ram #(.Width(ValW), .Depth(MaxRowLength)) u_middle_east (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cell_q),
    .raddr_i (col_q + ColW'(1)),
    .rdata_o (east_rd)
  );

  assign op_push_o = s1_valid_q && !s1_row1_q;

  always_comb begin
    op_o.center = s1_row0_q ? s1_cell_q : center_rd;
    op_o.north  = north_rd;
    op_o.west   = left_q;
    op_o.east   = east_rd;
    op_o.south  = s1_cell_q;
    op_o.upd    = !s1_row0_q && !s1_col0_q && !s1_last_col_q;
    op_o.second = s1_last_row_q;
    op_o.done   = s1_last_row_q && s1_last_col_q;
  end

endmodule

[rtl/core/hds_op_queue.sv]
// Short queue of stencil operations between the front and back ends.
module hds_op_queue import hds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  op_t                op_i,
  input  logic               pop_i,
  output logic               valid_o,
  output op_t                op_o,
  output logic [OpqCntW-1:0] count_o
);

  op_t                mem_q [OpqDepth];
  logic [OpqIdxW-1:0] wr_q, rd_q;
  logic [OpqCntW-1:0] cnt_q;
  logic               do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign op_o    = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + OpqIdxW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + OpqIdxW'(1);
      end
      cnt_q <= cnt_q + OpqCntW'(push_i) - OpqCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

[rtl/core/hds_back.sv]
// Back end: diffusion arithmetic pipeline and result queue.
module hds_back import hds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [FactorW-1:0]  step_factor_i,
  input  logic                op_valid_i,
  input  op_t                 op_i,
  output logic                op_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output res_t                res_o
);

  logic                    va_q, vb_q;
  logic [ValW-1:0]         a_center_q, a_south_q, b_center_q, b_south_q;
  logic                    a_upd_q, a_second_q, a_done_q;
  logic                    b_upd_q, b_second_q, b_done_q;
  logic signed [DiffW-1:0] diff_d, a_diff_q;
  logic signed [ProdW-1:0] b_prod_q, rnd;
  logic signed [DiffW-1:0] quo;
  logic signed [SumW-1:0]  sum;
  logic [ValW-1:0]         sat, value;

  res_t                    mem_q [OutqDepth];
  logic [OutqIdxW-1:0]     wr_q, rd_q;
  logic [OutqCntW-1:0]     cnt_q;
  logic [OutqCntW+1:0]     need;
  logic                    do_pop;
  logic [1:0]              n_push;
  res_t                    res0, res1;

  // each operation in flight may still add two results
  assign need = (OutqCntW+2)'(cnt_q) + (OutqCntW+2)'({va_q, 1'b0})
              + (OutqCntW+2)'({vb_q, 1'b0}) + (OutqCntW+2)'(2);
  assign op_pop_o = op_valid_i && (32'(need) <= OutqDepth);

  assign diff_d = $signed(DiffW'(op_i.north) + DiffW'(op_i.west) + DiffW'(op_i.east)
                + DiffW'(op_i.south) - DiffW'({op_i.center, 2'b00}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= op_pop_o;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_center_q <= op_i.center;
    a_south_q  <= op_i.south;
    a_upd_q    <= op_i.upd;
    a_second_q <= op_i.second;
    a_done_q   <= op_i.done;
    a_diff_q   <= diff_d;
    b_center_q <= a_center_q;
    b_south_q  <= a_south_q;
    b_upd_q    <= a_upd_q;
    b_second_q <= a_second_q;
    b_done_q   <= a_done_q;
    b_prod_q   <= ProdW'(a_diff_q) * $signed(ProdW'({1'b0, step_factor_i}));
  end

  // round half up, then saturate to the value range
  assign rnd = b_prod_q + ProdW'(32768);
  assign quo = rnd[ProdW-1:ValW];
  assign sum = $signed(SumW'({1'b0, b_center_q})) + SumW'(quo);

  always_comb begin
    if (sum < 0) begin
      sat = '0;
    end else if (sum > $signed(SumW'({ValW{1'b1}}))) begin
      sat = '1;
    end else begin
      sat = sum[ValW-1:0];
    end
    value = b_upd_q ? sat : b_center_q;
  end

  assign res0.value = value;
  assign res0.last  = !b_second_q;
  assign res0.done  = 1'b0;
  assign res1.value = b_south_q;
  assign res1.last  = 1'b1;
  assign res1.done  = b_done_q;

  assign n_push  = vb_q ? (b_second_q ? 2'd2 : 2'd1) : 2'd0;
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OutqIdxW'(n_push);
      if (do_pop) begin
        rd_q <= rd_q + OutqIdxW'(1);
      end
      cnt_q <= cnt_q + OutqCntW'(n_push) - OutqCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q) begin
      mem_q[wr_q] <= res0;
      if (b_second_q) begin
        mem_q[wr_q + OutqIdxW'(1)] <= res1;
      end
    end
  end

endmodule

[rtl/core/heat_diffusion_stencil_step_core.sv]
// Top level of the five-point explicit diffusion stencil core.
//
// Cells enter in raster order through a queue-style port: a transaction
// completes when push is high and full is low. Results leave the same way:
// new_value_o, last_of_run_o and grid_done_o show the oldest result while
// empty is low, and pop takes it. Row 0 cells come back unchanged, row 1
// cells produce nothing, and each later cell yields the cell above it,
// updated unless it lies in the first or last column; cells of the last
// row yield a second result carrying themselves. Throughput is one cell
// per cycle while full is low, set by the single read of each line store
// per cell; on the last row each cell yields two results, and the result
// port gives one result per cycle while pop is high. The APB port (0x0
// row_length, 0x4 row_count, 0x8 step_factor) is written while the core
// is idle; a geometry write restarts the grid at row 0, column 0. Reset
// sets 1024, 1024 and 4096, clears position and queues; line stores are
// not cleared. When the receiver stalls, the result queue fills, then the
// operation queue, and full rises.
module heat_diffusion_stencil_step_core import hds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [ValW-1:0]     cell_value_i,
  output logic                empty,
  input  logic                pop,
  output logic [ValW-1:0]     new_value_o,
  output logic                last_of_run_o,
  output logic                grid_done_o
);

  cfg_t               cfg_q;
  logic               wr_en, restart;
  logic [1:0]         reg_idx;
  logic               op_push, op_valid, op_pop;
  op_t                op_in, op_out;
  logic [OpqCntW-1:0] opq_count;
  res_t               res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && ((reg_idx == RegRowLength) || (reg_idx == RegRowCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_length  <= LenW'(1024);
      cfg_q.row_count   <= RowW'(1024);
      cfg_q.step_factor <= FactorW'(4096);
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRowLength:  cfg_q.row_length  <= pwdata[LenW-1:0];
        RegRowCount:   cfg_q.row_count   <= pwdata[RowW-1:0];
        RegStepFactor: cfg_q.step_factor <= pwdata[FactorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRowLength:  prdata = ApbDataW'(cfg_q.row_length);
      RegRowCount:   prdata = ApbDataW'(cfg_q.row_count);
      RegStepFactor: prdata = ApbDataW'(cfg_q.step_factor);
      default:       prdata = '0;
    endcase
  end

  hds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .restart_i    (restart),
    .push_i       (push),
    .cell_value_i (cell_value_i),
    .opq_count_i  (opq_count),
    .full_o       (full),
    .op_push_o    (op_push),
    .op_o         (op_in)
  );

  hds_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .pop_i   (op_pop),
    .valid_o (op_valid),
    .op_o    (op_out),
    .count_o (opq_count)
  );

  hds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_factor_i (cfg_q.step_factor),
    .op_valid_i    (op_valid),
    .op_i          (op_out),
    .op_pop_o      (op_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .res_o         (res)
  );

  assign new_value_o   = res.value;
  assign last_of_run_o = res.last;
  assign grid_done_o   = res.done;

endmodule

[bench/tb_heat_diffusion_stencil_step_core.sv]
// Self-checking testbench for the five-point diffusion stencil core.
module tb_heat_diffusion_stencil_step_core;
  import hds_pkg::*;

  localparam logic [1:0] RegSpare    = 2'd3;
  localparam int unsigned WideCells   = 120;
  localparam int unsigned RandomCells = 340;
  localparam int unsigned CalmCells   = 270;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                push;
  logic                full;
  logic [ValW-1:0]     cell_value;
  logic                empty;
  logic                pop;
  logic [ValW-1:0]     new_value_o;
  logic                last_of_run_o;
  logic                grid_done_o;

  heat_diffusion_stencil_step_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .cell_value_i  (cell_value),
    .empty         (empty),
    .pop           (pop),
    .new_value_o   (new_value_o),
    .last_of_run_o (last_of_run_o),
    .grid_done_o   (grid_done_o)
  );

  // stencil state mirrored from the stream
  logic [ValW-1:0] upper_store [MaxRowLength];
  logic [ValW-1:0] middle_store[MaxRowLength];
  logic [ValW-1:0] west_hold;
  int unsigned     col_pos;
  int unsigned     row_pos;
  logic [LenW-1:0]    len_cfg;
  logic [RowW-1:0]    count_cfg;
  logic [FactorW-1:0] factor_cfg;

  res_t        expected_cells[$];
  res_t        oldest;
  int unsigned mismatch_count;
  int unsigned cells_sent;
  int unsigned results_checked;
  int unsigned random_cells;
  int unsigned geometry_count;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned grid_width();
    if (len_cfg < 3) return 3;
    if (len_cfg > MaxRowLength) return MaxRowLength;
    return 32'(len_cfg);
  endfunction

  function automatic int unsigned grid_height();
    return (count_cfg < 3) ? 3 : 32'(count_cfg);
  endfunction

  function automatic logic [ApbDataW-1:0] reg_mask(input logic [1:0] idx);
    case (idx)
      RegRowLength:  return ApbDataW'((1 << LenW) - 1);
      RegRowCount:   return ApbDataW'((1 << RowW) - 1);
      RegStepFactor: return ApbDataW'((1 << FactorW) - 1);
      default:       return '0;
    endcase
  endfunction

  function automatic logic [ValW-1:0] jacobi_update(input logic [ValW-1:0] ctr, nn, ww, ee, ss);
    longint lap;
    longint scaled;
    longint sum;
    lap = longint'(nn) + longint'(ww) + longint'(ee) + longint'(ss) - 4 * longint'(ctr);
    scaled = (lap * longint'(factor_cfg) + 32768) >>> 16;
    sum = longint'(ctr) + scaled;
    if (sum < 0) return '0;
    if (sum > 65535) return '1;
    return ValW'(sum);
  endfunction

  task automatic reset_model();
    for (int i = 0; i < MaxRowLength; i++) begin
      upper_store[ColW'(i)]  = '0;
      middle_store[ColW'(i)] = '0;
    end
    west_hold  = '0;
    col_pos    = 0;
    row_pos    = 0;
    len_cfg    = LenW'(1024);
    count_cfg  = RowW'(1024);
    factor_cfg = FactorW'(4096);
  endtask

  task automatic apply_register(input logic [1:0] idx, input logic [ApbDataW-1:0] data);
    case (idx)
      RegRowLength: begin
        len_cfg = data[LenW-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      RegRowCount: begin
        count_cfg = data[RowW-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      RegStepFactor: begin
        factor_cfg = data[FactorW-1:0];
      end
      default: ;
    endcase
  endtask

  // expected results for one accepted cell
  task automatic model_cell(input logic [ValW-1:0] arrival);
    int unsigned     width;
    int unsigned     height;
    logic [ValW-1:0] north;
    logic [ValW-1:0] center;
    logic [ValW-1:0] east;
    logic [ValW-1:0] upd;
    logic            last_row;
    logic            last_col;
    width    = grid_width();
    height   = grid_height();
    last_row = (row_pos == height - 1);
    last_col = (col_pos == width - 1);
    north    = upper_store[ColW'(col_pos)];
    center   = middle_store[ColW'(col_pos)];
    east     = (col_pos + 1 < width) ? middle_store[ColW'(col_pos + 1)] : '0;
    if (row_pos == 0) begin
      expected_cells.push_back('{value: arrival, last: 1'b1, done: 1'b0});
    end else if (row_pos >= 2) begin
      upd = center;
      if (col_pos != 0 && !last_col) upd = jacobi_update(center, north, west_hold, east, arrival);
      expected_cells.push_back('{value: upd, last: !last_row, done: 1'b0});
      if (last_row) expected_cells.push_back('{value: arrival, last: 1'b1, done: last_col});
    end
    upper_store[ColW'(col_pos)]  = center;
    middle_store[ColW'(col_pos)] = arrival;
    west_hold = center;
    col_pos++;
    if (col_pos >= width) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= height) row_pos = 0;
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    apply_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [ApbDataW-1:0] want;
    want = '0;
    case (idx)
      RegRowLength:  want = ApbDataW'(len_cfg);
      RegRowCount:   want = ApbDataW'(count_cfg);
      RegStepFactor: want = ApbDataW'(factor_cfg);
      default:       ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & reg_mask(idx)) !== want) begin
      $display("%0t register %0d: expected %0d, actual %0d", $time, idx, want,
               prdata & reg_mask(idx));
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // idle the core, then write with random junk above the register width
  task automatic set_register(input logic [1:0] idx, input int unsigned value);
    drain_results();
    apb_write(idx, ($urandom & ~reg_mask(idx)) | (ApbDataW'(value) & reg_mask(idx)));
    if (idx == RegRowLength || idx == RegRowCount) geometry_count++;
  endtask

  task automatic send_cell(input logic [ValW-1:0] val);
    if (!steady && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push       <= 1'b1;
    cell_value <= val;
    do @(posedge clk_i); while (full);
    model_cell(val);
    cells_sent++;
  endtask

  function automatic logic [ValW-1:0] random_cell(input int unsigned style,
                                                  input int unsigned base);
    int v;
    case (style)
      0: return ValW'($urandom);
      1: begin
        v = int'(base) + int'($urandom_range(0, 512)) - 256;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return ValW'(v);
      end
      default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endcase
  endfunction

  task automatic test_registers();
    check_register(RegRowLength);
    check_register(RegRowCount);
    check_register(RegStepFactor);
    set_register(RegRowLength, 2047);
    set_register(RegRowCount, 65535);
    set_register(RegStepFactor, 32767);
    check_register(RegRowLength);
    check_register(RegRowCount);
    check_register(RegStepFactor);
    set_register(RegSpare, $urandom);
    set_register(RegRowLength, 0);
    set_register(RegRowCount, 0);
    set_register(RegStepFactor, 0);
    check_register(RegRowLength);
    check_register(RegRowCount);
    check_register(RegStepFactor);
  endtask

  // 3x3 grids from undersized geometry; hot and cold centers hit both rails
  task automatic test_border_and_saturation();
    set_register(RegRowLength, 2);
    set_register(RegRowCount, 0);
    set_register(RegStepFactor, 32767);
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? ValW'(30000) : '1);
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? '1 : '0);
  endtask

  task automatic test_geometry_restart();
    set_register(RegRowLength, 5);
    set_register(RegRowCount, 65535);
    set_register(RegStepFactor, 0);
    repeat (23) send_cell(random_cell(0, 0));
    set_register(RegRowCount, 4);
    set_register(RegStepFactor, 8192);
    repeat (27) send_cell(random_cell(1, 20000));
    set_register(RegRowLength, 6);
    repeat (24) send_cell(random_cell(0, 0));
  endtask

  // oversized row length clamps to the line store depth
  task automatic test_clamped_width();
    set_register(RegRowLength, 2047);
    set_register(RegRowCount, 3);
    set_register(RegStepFactor, 16384);
    repeat (WideCells) send_cell(random_cell(0, 0));
  endtask

  task automatic test_random_grids();
    int unsigned phase;
    int unsigned cells;
    int unsigned style;
    int unsigned base;
    phase = 0;
    while (random_cells < RandomCells) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) set_register(RegRowLength, $urandom_range(0, 2));
        else if ($urandom_range(0, 4) == 0) set_register(RegRowLength, $urandom_range(13, 64));
        else set_register(RegRowLength, $urandom_range(3, 12));
        if ($urandom_range(0, 9) == 0) set_register(RegRowCount, $urandom_range(0, 2));
        else set_register(RegRowCount, $urandom_range(3, 7));
      end
      if (phase == 0 || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:       set_register(RegStepFactor, 16384);
          1, 2:    set_register(RegStepFactor, $urandom_range(0, 32767));
          default: set_register(RegStepFactor, $urandom_range(0, 16384));
        endcase
      end
      cells = grid_width() * grid_height() * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) cells = $urandom_range(1, cells);
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 65535);
      for (int i = 0; i < cells && random_cells < RandomCells; i++) begin
        steady = (random_cells >= CalmCells);
        send_cell(random_cell(style % 3, base));
        random_cells++;
      end
      phase++;
    end
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_cells.size() == 0) begin
        $display("%0t result with nothing expected: value %0d last %0b done %0b", $time,
                 new_value_o, last_of_run_o, grid_done_o);
        mismatch_count++;
      end else begin
        oldest = expected_cells.pop_front();
        results_checked++;
        if (new_value_o !== oldest.value) begin
          $display("%0t new_value: expected %0d, actual %0d", $time, oldest.value, new_value_o);
          mismatch_count++;
        end
        if (last_of_run_o !== oldest.last) begin
          $display("%0t last_of_run: expected %0b, actual %0b", $time, oldest.last,
                   last_of_run_o);
          mismatch_count++;
        end
        if (grid_done_o !== oldest.done) begin
          $display("%0t grid_done: expected %0b, actual %0b", $time, oldest.done, grid_done_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned hold_off;
    hold_off = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        pop <= 1'b0;
        hold_off--;
      end else begin
        pop <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0) hold_off = $urandom_range(1, 8);
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_heat_diffusion_stencil_step_core: errors");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    cell_value <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    mismatch_count  = 0;
    cells_sent      = 0;
    results_checked = 0;
    random_cells    = 0;
    geometry_count  = 0;
    steady          = 1'b0;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_registers();
    test_border_and_saturation();
    test_geometry_restart();
    test_clamped_width();
    test_random_grids();
    $display("sent %0d cells (%0d in random grids), checked %0d results", cells_sent,
             random_cells, results_checked);
    $display("geometry writes %0d, covering clamped, oversized and wrapped grids",
             geometry_count);
    if (mismatch_count == 0) begin
      $display("tb_heat_diffusion_stencil_step_core: clean");
    end else begin
      $display("tb_heat_diffusion_stencil_step_core: errors");
    end
    $finish;
  end

endmodule
